[src/ray_sphere_closest_hit_unit_macros.svh]
// Assertion macros for the ray/sphere closest-hit unit.
`ifndef RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSCH_ASSERT_NOW(lbl, ante, cons, msg)
`define RSCH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/rsch_pkg.sv]
// Shared types, constants and the product schedule of the closest-hit unit.
package rsch_pkg;

  localparam int DEF_MAX_SPHERES = 16;
  localparam int OW  = 68;   // signed operand width of the multiplier
  localparam int PW  = 136;  // product and sum width
  localparam int RW  = 134;  // radicand width of the square root
  localparam int NW  = 85;   // dividend width, also quotient width
  localparam int DVW = 64;   // divisor width
  localparam int SQI = 67;   // square root iterations
  localparam int SW  = 67;   // root width
  localparam logic [30:0] QMAX = 31'h7FFF_FFFF;

  typedef enum logic [0:0] {CMD_LOAD = 1'b0, CMD_CAST = 1'b1} cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_ISSUE, ST_MUL_WAIT, ST_FETCH, ST_CO, ST_SQRT_ISSUE,
    ST_SQRT_WAIT, ST_ROOT, ST_DIV_ISSUE, ST_DIV_WAIT, ST_NEXT, ST_DONE
  } state_t;

  typedef enum logic [0:0] {DSU_SQRT, DSU_DIV} dsu_mode_t;

  typedef struct packed {
    logic      start;
    dsu_mode_t mode;
  } dsu_req_t;

  typedef enum logic [3:0] {
    SEL_DX, SEL_DY, SEL_DZ, SEL_COX, SEL_COY, SEL_COZ, SEL_RAD, SEL_A, SEL_H, SEL_C
  } sel_t;

  typedef enum logic [2:0] {DST_NONE, DST_A, DST_H, DST_C, DST_DISC} dst_t;

  typedef struct packed {
    sel_t xsel;
    sel_t ysel;
    logic first;
    logic neg;
    dst_t dest;
  } step_t;

  localparam logic [3:0] STEP_A_LAST    = 4'd2;
  localparam logic [3:0] STEP_SPH_FIRST = 4'd3;
  localparam logic [3:0] STEP_LAST      = 4'd11;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] rad;
  } sphere_t;

  // Product schedule: a = D.D, h = CO.D, c = CO.CO - r*r, disc = h*h - a*c
  function automatic step_t step_fn(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd0:    s = '{SEL_DX,  SEL_DX,  1'b1, 1'b0, DST_NONE};
      4'd1:    s = '{SEL_DY,  SEL_DY,  1'b0, 1'b0, DST_NONE};
      4'd2:    s = '{SEL_DZ,  SEL_DZ,  1'b0, 1'b0, DST_A};
      4'd3:    s = '{SEL_COX, SEL_DX,  1'b1, 1'b0, DST_NONE};
      4'd4:    s = '{SEL_COY, SEL_DY,  1'b0, 1'b0, DST_NONE};
      4'd5:    s = '{SEL_COZ, SEL_DZ,  1'b0, 1'b0, DST_H};
      4'd6:    s = '{SEL_COX, SEL_COX, 1'b1, 1'b0, DST_NONE};
      4'd7:    s = '{SEL_COY, SEL_COY, 1'b0, 1'b0, DST_NONE};
      4'd8:    s = '{SEL_COZ, SEL_COZ, 1'b0, 1'b0, DST_NONE};
      4'd9:    s = '{SEL_RAD, SEL_RAD, 1'b0, 1'b1, DST_C};
      4'd10:   s = '{SEL_H,   SEL_H,   1'b1, 1'b0, DST_NONE};
      4'd11:   s = '{SEL_A,   SEL_C,   1'b0, 1'b1, DST_DISC};
      default: s = '{SEL_DX,  SEL_DX,  1'b1, 1'b0, DST_NONE};
    endcase
    return s;
  endfunction

endpackage

[src/rsch_store.sv]
// Sphere store: one write port, one registered read port.
module rsch_store import rsch_pkg::*; #(
  parameter int MAX_SPHERES = DEF_MAX_SPHERES,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sphere_t       wdata,
  input  logic [AW-1:0] raddr,
  output sphere_t       rdata
);

  sphere_t mem [MAX_SPHERES];

  // Write a loaded sphere
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the current slot every cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/rsch_mul.sv]
// Shift-add multiplier: one wide add per cycle, stops when the multiplier empties.
module rsch_mul import rsch_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [OW-1:0] x_mag,
  input  logic [OW-1:0] y_mag,
  output logic          done,
  output logic [PW-1:0] prod
);

  logic          running;
  logic [PW-1:0] mc;
  logic [PW-1:0] acc;
  logic [OW-1:0] mp;

  assign done = running && (mp == '0);
  assign prod = acc;

  // Track activity
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
    end else if (done) begin
      running <= 1'b0;
    end
  end

  // Load operands, then add and shift
  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= PW'(x_mag);
      mp  <= y_mag;
      acc <= '0;
    end else if (running && (mp != '0)) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

[src/rsch_dsu.sv]
// Square root and division unit sharing one subtractor, one result bit per cycle.
module rsch_dsu import rsch_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  dsu_req_t       req,
  input  logic [RW-1:0]  radicand,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  result
);

  logic           running;
  dsu_mode_t      mode;
  logic [RW-1:0]  p;
  logic [RW-1:0]  r;
  logic [RW-1:0]  e;
  logic [DVW-1:0] dv;
  logic [6:0]     cnt;
  logic [DVW:0]   rem_sh;
  logic [RW-1:0]  minu;
  logic [RW-1:0]  subt;
  logic [RW:0]    diff;
  logic           borrow;

  // Shared subtract and compare
  always_comb begin
    rem_sh = {e[DVW-1:0], p[NW-1]};
    minu   = (mode == DSU_SQRT) ? p : RW'(rem_sh);
    subt   = (mode == DSU_SQRT) ? (r | e) : RW'(dv);
    diff   = {1'b0, minu} - {1'b0, subt};
    borrow = diff[RW];
  end

  assign done   = running && (cnt == '0);
  assign result = r[NW-1:0];

  // Track activity
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (req.start) begin
      running <= 1'b1;
    end else if (done) begin
      running <= 1'b0;
    end
  end

  // Load, then iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      r    <= '0;
      dv   <= divisor;
      if (req.mode == DSU_SQRT) begin
        p   <= radicand;
        e   <= {2'b01, {(RW-2){1'b0}}};
        cnt <= 7'(SQI);
      end else begin
        p   <= RW'(dividend);
        e   <= '0;
        cnt <= 7'(NW);
      end
    end else if (running && (cnt != '0)) begin
      cnt <= cnt - 7'd1;
      if (mode == DSU_SQRT) begin
        if (!borrow) begin
          p <= diff[RW-1:0];
          r <= (r >> 1) | e;
        end else begin
          r <= r >> 1;
        end
        e <= e >> 2;
      end else begin
        p <= p << 1;
        e <= borrow ? RW'(rem_sh) : diff[RW-1:0];
        r <= {r[RW-2:0], ~borrow};
      end
    end
  end

endmodule

[src/ray_sphere_closest_hit_unit.sv]
// Top level: sequencer and datapath of the ray/sphere closest-hit unit.
//
// Usage: a request is taken when start is high and busy is low. command
// selects a sphere load (slot, point_*, radius) or a ray cast (point_*,
// dir_*, t_min, t_max). Each request gives exactly one result, shown on
// hit, hit_index and hit_distance for one cycle while done is high; the
// receiver cannot stall, so it must take the result in that cycle.
// sphere_count is written over the cfg channel (cfg_ready is always high);
// the user must write it only while the unit is idle, which the block
// itself does not enforce. A load goes straight to reporting. A cast runs
// one shared shift-add multiplier (its run length follows the bit length
// of its second operand) and one shared square root / divide unit. Per
// cast: 3 products for D.D, then per sphere a fetch, 9 products, one
// square root and up to two divisions (fewer on a miss), then the report.
// The next request is taken in the cycle the result is shown.
// Reset clears the sequencer and sphere_count; the store is not cleared,
// and a slot must be loaded before a cast covers it.
`include "ray_sphere_closest_hit_unit_macros.svh"
module ray_sphere_closest_hit_unit import rsch_pkg::*; #(
  parameter int MAX_SPHERES = DEF_MAX_SPHERES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [3:0]         slot,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        radius,
  input  logic [30:0]        t_min,
  input  logic [30:0]        t_max,
  output logic               done,
  output logic               hit,
  output logic [3:0]         hit_index,
  output logic [30:0]        hit_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW = $clog2(MAX_SPHERES + 1);
  localparam int CW = (KW > 5) ? KW : 5;

  state_t state, state_next;

  logic [4:0]         sphere_count;
  logic [CW-1:0]      ncount;
  logic signed [31:0] ox, oy, oz, dx, dy, dz;
  logic [30:0]        tmin, tmax;
  logic [CW-1:0]      k;
  logic [3:0]         step;
  logic signed [PW-1:0] sum;
  logic [63:0]        a;
  logic signed [OW-1:0] h, c;
  logic signed [32:0] cox, coy, coz;
  logic [30:0]        rad;
  logic               psign;
  logic [SW-1:0]      sroot;
  logic signed [69:0] num0, num1, numj;
  logic               root_sel;
  logic               found;
  logic [30:0]        best;
  logic [AW-1:0]      best_idx;

  step_t              cur;
  logic signed [OW-1:0] xv, yv;
  logic [OW-1:0]      x_mag, y_mag;
  logic               mul_start, mul_done;
  logic [PW-1:0]      prod;
  logic signed [PW-1:0] base, sum_acc;
  dsu_req_t           dsu_req;
  logic               dsu_done;
  logic [NW-1:0]      dsu_res;
  logic [30:0]        tq;
  logic               take;
  logic               mem_we;
  sphere_t            wsph, rsph;

  function automatic logic signed [OW-1:0] pick(input sel_t s);
    logic signed [OW-1:0] v;
    case (s)
      SEL_DX:  v = OW'(dx);
      SEL_DY:  v = OW'(dy);
      SEL_DZ:  v = OW'(dz);
      SEL_COX: v = OW'(cox);
      SEL_COY: v = OW'(coy);
      SEL_COZ: v = OW'(coz);
      SEL_RAD: v = $signed({{(OW-31){1'b0}}, rad});
      SEL_A:   v = $signed({{(OW-64){1'b0}}, a});
      SEL_H:   v = h;
      SEL_C:   v = c;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign ncount    = (CW'(sphere_count) > CW'(MAX_SPHERES)) ? CW'(MAX_SPHERES)
                                                            : CW'(sphere_count);

  // Operand selection for the multiplier
  always_comb begin
    cur   = step_fn(step);
    xv    = pick(cur.xsel);
    yv    = pick(cur.ysel);
    x_mag = xv[OW-1] ? OW'(-xv) : OW'(xv);
    y_mag = yv[OW-1] ? OW'(-yv) : OW'(yv);
    base  = cur.first ? '0 : sum;
    sum_acc = psign ? (base - $signed(prod)) : (base + $signed(prod));
  end

  // Root saturation and interval test
  always_comb begin
    numj = root_sel ? num1 : num0;
    tq   = (dsu_res[NW-1:31] != '0) ? QMAX : dsu_res[30:0];
    take = (tq > tmin) && ((tmax == QMAX) || (tq < tmax)) && (!found || (tq < best));
  end

  // Store write for a load
  always_comb begin
    wsph   = '{cx: point_x, cy: point_y, cz: point_z, rad: radius};
    mem_we = (state == ST_IDLE) && start && (command == CMD_LOAD)
             && (32'(slot) < MAX_SPHERES);
  end

  rsch_store #(.MAX_SPHERES(MAX_SPHERES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(slot)),
    .wdata (wsph),
    .raddr (k[AW-1:0]),
    .rdata (rsph)
  );

  rsch_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x_mag (x_mag),
    .y_mag (y_mag),
    .done  (mul_done),
    .prod  (prod)
  );

  rsch_dsu u_dsu (
    .clk      (clk),
    .rst      (rst),
    .req      (dsu_req),
    .radicand (sum[RW-1:0]),
    .dividend ({numj[68:0], 16'h0000}),
    .divisor  (a),
    .done     (dsu_done),
    .result   (dsu_res)
  );

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit starts
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    dsu_req      = '{start: 1'b0, mode: DSU_SQRT};
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (command == CMD_LOAD) ? ST_DONE : ST_MUL_ISSUE;
        end
      end
      ST_MUL_ISSUE: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (step == STEP_A_LAST) begin
            state_next = ((sum_acc[63:0] == '0) || (ncount == '0)) ? ST_DONE : ST_FETCH;
          end else if (step == STEP_LAST) begin
            state_next = sum_acc[PW-1] ? ST_NEXT : ST_SQRT_ISSUE;
          end else begin
            state_next = ST_MUL_ISSUE;
          end
        end
      end
      ST_FETCH: state_next = ST_CO;
      ST_CO:    state_next = ST_MUL_ISSUE;
      ST_SQRT_ISSUE: begin
        dsu_req    = '{start: 1'b1, mode: DSU_SQRT};
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (dsu_done) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: state_next = ST_DIV_ISSUE;
      ST_DIV_ISSUE: begin
        if (numj[69] || (numj == '0)) begin
          state_next = root_sel ? ST_NEXT : ST_DIV_ISSUE;
        end else begin
          dsu_req    = '{start: 1'b1, mode: DSU_DIV};
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (dsu_done) begin
          state_next = root_sel ? ST_NEXT : ST_DIV_ISSUE;
        end
      end
      ST_NEXT: begin
        state_next = (CW'(k + 1'b1) < ncount) ? ST_FETCH : ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sphere_count <= cfg_data;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          ox       <= point_x;
          oy       <= point_y;
          oz       <= point_z;
          dx       <= dir_x;
          dy       <= dir_y;
          dz       <= dir_z;
          tmin     <= t_min;
          tmax     <= t_max;
          step     <= '0;
          k        <= '0;
          found    <= 1'b0;
          best     <= QMAX;
          best_idx <= '0;
        end
      end
      ST_MUL_ISSUE: begin
        psign <= xv[OW-1] ^ yv[OW-1] ^ cur.neg;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          sum <= sum_acc;
          case (cur.dest)
            DST_A:   a <= sum_acc[63:0];
            DST_H:   h <= sum_acc[OW-1:0];
            DST_C:   c <= sum_acc[OW-1:0];
            default: ;
          endcase
          step <= step + 4'd1;
        end
      end
      ST_CO: begin
        cox  <= 33'(ox) - 33'($signed(rsph.cx));
        coy  <= 33'(oy) - 33'($signed(rsph.cy));
        coz  <= 33'(oz) - 33'($signed(rsph.cz));
        rad  <= rsph.rad;
        step <= STEP_SPH_FIRST;
      end
      ST_SQRT_WAIT: begin
        if (dsu_done) begin
          sroot <= dsu_res[SW-1:0];
        end
      end
      ST_ROOT: begin
        num0     <= $signed({3'b000, sroot}) - 70'(h);
        num1     <= -70'(h) - $signed({3'b000, sroot});
        root_sel <= 1'b0;
      end
      ST_DIV_ISSUE: begin
        if ((numj[69] || (numj == '0)) && !root_sel) begin
          root_sel <= 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (dsu_done) begin
          if (take) begin
            found    <= 1'b1;
            best     <= tq;
            best_idx <= k[AW-1:0];
          end
          root_sel <= 1'b1;
        end
      end
      ST_NEXT: begin
        k <= CW'(k + 1'b1);
      end
      ST_DONE: begin
        hit          <= found;
        hit_index    <= 4'(best_idx);
        hit_distance <= best;
      end
      default: ;
    endcase
  end

  `RSCH_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe lasted more than one cycle")
  `RSCH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not make unit busy")
  `RSCH_ASSERT_NOW(a_miss_fields, done && !hit, (hit_index == 4'd0) && (hit_distance == QMAX), "miss result fields wrong")

endmodule
